### hdl/roi_thresholded_depth_mean_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ROI thresholded depth mean block
// Shared shorthand for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef ROI_THRESHOLDED_DEPTH_MEAN_DEFINES_SVH
`define ROI_THRESHOLDED_DEPTH_MEAN_DEFINES_SVH

// Checked on every rising edge of clk_i outside reset.
`define RTDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define RTDM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/rtdm_pkg.sv
// ----------------------------------------------------------------------------
// ROI thresholded depth mean package
// Widths, register codes, reset values and shared types of the block.
// ----------------------------------------------------------------------------
package rtdm_pkg;

  // Field widths.
  localparam int DepthW   = 16;
  localparam int BoxW     = 12;
  localparam int SpanW    = 12;
  localparam int DimW     = 11;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 3;

  // Default frame size limits.
  localparam int MaxCols = 1024;
  localparam int MaxRows = 1024;

  // Queue between the classifier and the accumulator.
  localparam int QueueDepth = 4;

  // Register reset values.
  localparam logic [BoxW-1:0]   BoxLeftRst    = '0;
  localparam logic [BoxW-1:0]   BoxTopRst     = '0;
  localparam logic [SpanW-1:0]  BoxSpanXRst   = SpanW'(256);
  localparam logic [SpanW-1:0]  BoxSpanYRst   = SpanW'(192);
  localparam logic [DimW-1:0]   FrameColsRst  = DimW'(256);
  localparam logic [DimW-1:0]   FrameRowsRst  = DimW'(192);
  localparam logic [DepthW-1:0] DepthLimitRst = '1;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_BOX_LEFT    = 3'd0,
    CFG_BOX_TOP     = 3'd1,
    CFG_BOX_SPAN_X  = 3'd2,
    CFG_BOX_SPAN_Y  = 3'd3,
    CFG_FRAME_COLS  = 3'd4,
    CFG_FRAME_ROWS  = 3'd5,
    CFG_DEPTH_LIMIT = 3'd6
  } cfg_reg_e;

  // Current configuration as seen by the classifier.
  typedef struct packed {
    logic [BoxW-1:0]   box_left;
    logic [BoxW-1:0]   box_top;
    logic [SpanW-1:0]  box_span_x;
    logic [SpanW-1:0]  box_span_y;
    logic [DimW-1:0]   frame_cols;
    logic [DimW-1:0]   frame_rows;
    logic [DepthW-1:0] depth_limit;
  } cfg_t;

  // One classified pixel on its way to the accumulator.
  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic              counted;
    logic              last;
  } item_t;

endpackage

### hdl/rtdm_in_if.sv
// ----------------------------------------------------------------------------
// Depth pixel channel
// Valid/ready channel that carries one depth pixel and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface rtdm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rtdm_pkg::DepthW-1:0] depth_sample;
  logic                        frame_end;

  modport source (output valid, depth_sample, frame_end, input ready);
  modport sink   (input valid, depth_sample, frame_end, output ready);
endinterface

### hdl/rtdm_out_if.sv
// ----------------------------------------------------------------------------
// Mean result channel
// Valid/ready channel that carries one frame's mean depth and its valid flag.
// ----------------------------------------------------------------------------
interface rtdm_out_if;
  logic                        valid;
  logic                        ready;
  logic [rtdm_pkg::DepthW-1:0] mean_depth;
  logic                        mean_valid;

  modport source (output valid, mean_depth, mean_valid, input ready);
  modport sink   (input valid, mean_depth, mean_valid, output ready);
endinterface

### hdl/rtdm_queue.sv
// ----------------------------------------------------------------------------
// Classified pixel queue
// Small flip-flop FIFO that decouples the classifier from the accumulator.
// ----------------------------------------------------------------------------
module rtdm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rtdm_pkg::item_t     data_i,
  output logic                full_o,
  input  logic                pop_i,
  output rtdm_pkg::item_t     data_o,
  output logic                empty_o
);

  localparam int PtrW = (rtdm_pkg::QueueDepth > 1) ? $clog2(rtdm_pkg::QueueDepth) : 1;
  localparam int FillW = $clog2(rtdm_pkg::QueueDepth + 1);

  rtdm_pkg::item_t  mem_q [rtdm_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (fill_q == FillW'(rtdm_pkg::QueueDepth));
  assign empty_o = (fill_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill level update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(rtdm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(rtdm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/rtdm_front.sv
// ----------------------------------------------------------------------------
// Pixel classifier
// Tracks raster position and decides per pixel whether it enters the mean.
// ----------------------------------------------------------------------------
module rtdm_front #(
  parameter int MAX_COLS = rtdm_pkg::MaxCols,
  parameter int MAX_ROWS = rtdm_pkg::MaxRows
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtdm_pkg::cfg_t     cfg_i,
  rtdm_in_if.sink            pix_i,
  output logic               push_o,
  output rtdm_pkg::item_t    item_o,
  input  logic               full_i
);

  localparam int ColW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DimMaxW = (ColW > RowW) ? ColW : RowW;
  // Holds box start plus span, and the largest frame size, as signed values.
  localparam int CmpW = (DimMaxW + 3 > rtdm_pkg::SpanW + 2) ? DimMaxW + 3
                                                            : rtdm_pkg::SpanW + 2;
  localparam logic signed [CmpW-1:0] MaxColsS = CmpW'(MAX_COLS);
  localparam logic signed [CmpW-1:0] MaxRowsS = CmpW'(MAX_ROWS);
  localparam logic signed [CmpW-1:0] OneS     = CmpW'(1);

  logic [ColW-1:0]         col_q, col_d;
  logic [RowW-1:0]         row_q, row_d;
  logic                    overrun_q, overrun_d;
  logic signed [CmpW-1:0]  col_s, row_s;
  logic signed [CmpW-1:0]  fc_s, fr_s, cols_s, rows_s;
  logic signed [CmpW-1:0]  left_s, top_s, right_s, bottom_s;
  logic                    in_x, in_y, depth_ok;
  logic                    accept;

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && !full_i;
  assign push_o      = accept;

  // Frame size clamped to one up to the maximum.
  always_comb begin
    fc_s = $signed(CmpW'(cfg_i.frame_cols));
    fr_s = $signed(CmpW'(cfg_i.frame_rows));
    if (cfg_i.frame_cols == '0) begin
      cols_s = OneS;
    end else if (fc_s > MaxColsS) begin
      cols_s = MaxColsS;
    end else begin
      cols_s = fc_s;
    end
    if (cfg_i.frame_rows == '0) begin
      rows_s = OneS;
    end else if (fr_s > MaxRowsS) begin
      rows_s = MaxRowsS;
    end else begin
      rows_s = fr_s;
    end
  end

  // Box test; positions are never negative, so a box start left of the
  // frame needs no separate clip.
  always_comb begin
    col_s    = $signed(CmpW'(col_q));
    row_s    = $signed(CmpW'(row_q));
    left_s   = CmpW'($signed(cfg_i.box_left));
    top_s    = CmpW'($signed(cfg_i.box_top));
    right_s  = left_s + $signed(CmpW'(cfg_i.box_span_x));
    bottom_s = top_s + $signed(CmpW'(cfg_i.box_span_y));
    in_x     = (col_s >= left_s) && (col_s < right_s) && (col_s < cols_s);
    in_y     = (row_s >= top_s) && (row_s < bottom_s) && (row_s < rows_s);
    depth_ok = (pix_i.depth_sample <= cfg_i.depth_limit);
  end

  always_comb begin
    item_o.depth   = pix_i.depth_sample;
    item_o.counted = !overrun_q && in_x && in_y && depth_ok;
    item_o.last    = pix_i.frame_end;
  end

  // Raster position: restart on frame end, hold after the last row.
  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    overrun_d = overrun_q;
    if (accept) begin
      if (pix_i.frame_end) begin
        col_d     = '0;
        row_d     = '0;
        overrun_d = 1'b0;
      end else if (!overrun_q) begin
        if (col_s >= cols_s - OneS) begin
          col_d = '0;
          if (row_s >= rows_s - OneS) begin
            overrun_d = 1'b1;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      overrun_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      overrun_q <= overrun_d;
    end
  end

endmodule

### hdl/rtdm_accum.sv
// ----------------------------------------------------------------------------
// Depth accumulator
// Sums counted depths and pixel count, hands both to the divider at frame end.
// ----------------------------------------------------------------------------
module rtdm_accum #(
  parameter int CNT_W = 21,
  parameter int SUM_W = 37
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtdm_pkg::item_t    item_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               start_o,
  output logic [SUM_W-1:0]   sum_o,
  output logic [CNT_W-1:0]   count_o,
  input  logic               start_ready_i
);

  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] cnt_add;

  // Totals including the pixel at the head of the queue.
  always_comb begin
    sum_add = sum_q + (item_i.counted ? SUM_W'(item_i.depth) : '0);
    cnt_add = cnt_q + (item_i.counted ? CNT_W'(1) : '0);
  end

  // A frame-end beat waits until the divider can take the totals.
  assign start_o = !empty_i && item_i.last;
  assign pop_o   = !empty_i && (!item_i.last || start_ready_i);
  assign sum_o   = sum_add;
  assign count_o = cnt_add;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (pop_o) begin
      if (item_i.last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_add;
        cnt_d = cnt_add;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### hdl/rtdm_divider.sv
// ----------------------------------------------------------------------------
// Mean divider
// Restoring divider, one quotient bit per cycle, with a held result register.
// ----------------------------------------------------------------------------
module rtdm_divider #(
  parameter int CNT_W = 21,
  parameter int SUM_W = 37
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   sum_i,
  input  logic [CNT_W-1:0]   count_i,
  output logic               start_ready_o,
  rtdm_out_if.source         mean_o
);

  localparam int QW    = rtdm_pkg::DepthW;
  localparam int StepW = $clog2(QW);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [SUM_W-1:0] rem_q;
  logic [SUM_W-1:0] dvs_q;
  logic [QW-1:0]    quo_q;
  logic [StepW-1:0] step_q;
  logic             mv_q;
  logic             ge;

  assign start_ready_o     = (state_q == ST_IDLE);
  assign ge                = (rem_q >= dvs_q);
  assign mean_o.valid      = (state_q == ST_DONE);
  assign mean_o.mean_depth = quo_q;
  assign mean_o.mean_valid = mv_q;

  // The mean never exceeds the largest depth, so the divisor starts shifted
  // up by one less than the quotient width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      dvs_q   <= '0;
      quo_q   <= '0;
      step_q  <= '0;
      mv_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            quo_q <= '0;
            if (count_i == '0) begin
              mv_q    <= 1'b0;
              state_q <= ST_DONE;
            end else begin
              rem_q   <= sum_i;
              dvs_q   <= SUM_W'(count_i) << (QW - 1);
              step_q  <= StepW'(QW - 1);
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (ge) begin
            rem_q <= rem_q - dvs_q;
          end
          quo_q <= {quo_q[QW-2:0], ge};
          dvs_q <= dvs_q >> 1;
          if (step_q == '0) begin
            mv_q    <= 1'b1;
            state_q <= ST_DONE;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        ST_DONE: begin
          if (mean_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/roi_thresholded_depth_mean.sv
// ----------------------------------------------------------------------------
// ROI thresholded depth mean
// Mean depth of the pixels inside a box and below a depth limit, per frame.
// ----------------------------------------------------------------------------
// Usage:
// Depth pixels enter on pix_i in raster order, one beat per pixel, with
// frame_end set on the last pixel of a frame. The block tracks column and row
// itself. Each frame-end beat yields exactly one beat on mean_o: the truncated
// mean depth and mean_valid, which is 0 (with mean_depth 0) if no pixel counted.
// Registers are to be written through cfg_we_i/cfg_idx_i/cfg_data_i only
// while idle; the block does not enforce this. Throughput is one pixel per
// cycle; the classifier takes a pixel whenever the four-entry queue in front
// of the accumulator has room. With the queue and divider idle, an accepted
// frame-end beat passes the queue register and the divider's launch step,
// then the bit-serial divider runs and the result beat is offered. A frame
// with no counted pixel skips the bit-serial divider and is offered once the
// frame-end beat has passed the queue register and the launch step. A second
// frame end waits at the accumulator until the previous result has been taken,
// pixels behind it pile up in the queue, and then pix_i.ready drops.
// A stalled result holds on mean_o until taken. Reset clears positions,
// totals, queue and divider, and loads the register defaults.
// ----------------------------------------------------------------------------
module roi_thresholded_depth_mean #(
  parameter int MAX_COLS = rtdm_pkg::MaxCols,
  parameter int MAX_ROWS = rtdm_pkg::MaxRows
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtdm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rtdm_pkg::CfgDataW-1:0] cfg_data_i,
  rtdm_in_if.sink                       pix_i,
  rtdm_out_if.source                    mean_o
);

  localparam int CntW = $clog2(MAX_COLS * MAX_ROWS + 1);
  localparam int SumW = CntW + rtdm_pkg::DepthW;

  rtdm_pkg::cfg_t  cfg_q;
  rtdm_pkg::item_t push_item;
  rtdm_pkg::item_t head_item;
  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  logic            div_start;
  logic            div_ready;
  logic [SumW-1:0] div_sum;
  logic [CntW-1:0] div_count;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.box_left    <= rtdm_pkg::BoxLeftRst;
      cfg_q.box_top     <= rtdm_pkg::BoxTopRst;
      cfg_q.box_span_x  <= rtdm_pkg::BoxSpanXRst;
      cfg_q.box_span_y  <= rtdm_pkg::BoxSpanYRst;
      cfg_q.frame_cols  <= rtdm_pkg::FrameColsRst;
      cfg_q.frame_rows  <= rtdm_pkg::FrameRowsRst;
      cfg_q.depth_limit <= rtdm_pkg::DepthLimitRst;
    end else if (cfg_we_i) begin
      unique case (rtdm_pkg::cfg_reg_e'(cfg_idx_i))
        rtdm_pkg::CFG_BOX_LEFT:    cfg_q.box_left    <= cfg_data_i[rtdm_pkg::BoxW-1:0];
        rtdm_pkg::CFG_BOX_TOP:     cfg_q.box_top     <= cfg_data_i[rtdm_pkg::BoxW-1:0];
        rtdm_pkg::CFG_BOX_SPAN_X:  cfg_q.box_span_x  <= cfg_data_i[rtdm_pkg::SpanW-1:0];
        rtdm_pkg::CFG_BOX_SPAN_Y:  cfg_q.box_span_y  <= cfg_data_i[rtdm_pkg::SpanW-1:0];
        rtdm_pkg::CFG_FRAME_COLS:  cfg_q.frame_cols  <= cfg_data_i[rtdm_pkg::DimW-1:0];
        rtdm_pkg::CFG_FRAME_ROWS:  cfg_q.frame_rows  <= cfg_data_i[rtdm_pkg::DimW-1:0];
        rtdm_pkg::CFG_DEPTH_LIMIT: cfg_q.depth_limit <= cfg_data_i[rtdm_pkg::DepthW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: position tracking and classification.
  rtdm_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .pix_i  (pix_i),
    .push_o (push),
    .item_o (push_item),
    .full_i (full)
  );

  // Queue between front and back.
  rtdm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_item),
    .empty_o (empty)
  );

  // Back: accumulation and division.
  rtdm_accum #(
    .CNT_W (CntW),
    .SUM_W (SumW)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (head_item),
    .empty_i       (empty),
    .pop_o         (pop),
    .start_o       (div_start),
    .sum_o         (div_sum),
    .count_o       (div_count),
    .start_ready_i (div_ready)
  );

  rtdm_divider #(
    .CNT_W (CntW),
    .SUM_W (SumW)
  ) u_divider (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (div_start),
    .sum_i         (div_sum),
    .count_i       (div_count),
    .start_ready_o (div_ready),
    .mean_o        (mean_o)
  );

endmodule

### hdl/rtdm_checker.sv
// ----------------------------------------------------------------------------
// ROI thresholded depth mean port checker
// Concurrent checks on the top-level result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "roi_thresholded_depth_mean_defines.svh"

module rtdm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [rtdm_pkg::DepthW-1:0] mean_depth_i,
  input logic                        mean_valid_i
);

  // No result beat is offered while reset is asserted.
  `RTDM_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |-> !out_valid_i, "result during reset")

  // Right after reset no frame can have finished yet.
  `RTDM_ASSERT(a_quiet_after_reset, $rose(rst_ni) |=> !out_valid_i, "result right after reset")

  // A stalled result beat holds its payload.
  `RTDM_ASSERT(a_stall_holds, out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_depth_i) && $stable(mean_valid_i), "stalled result changed")

  // An empty frame reports a zero mean.
  `RTDM_ASSERT(a_empty_is_zero, out_valid_i && !mean_valid_i |-> mean_depth_i == '0, "empty frame with nonzero mean")

endmodule

bind roi_thresholded_depth_mean rtdm_checker u_rtdm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (mean_o.valid),
  .out_ready_i  (mean_o.ready),
  .mean_depth_i (mean_o.mean_depth),
  .mean_valid_i (mean_o.mean_valid)
);
